// File: hw/rtl/bmprle_pkg.sv
package bmprle_pkg;

  localparam int unsigned COORD_BITS = 14;
  // cursor registers carry one bit beyond the coordinate width
  localparam int unsigned CUR_BITS   = COORD_BITS + 1;

  // result queue geometry
  localparam int unsigned OUT_DEPTH    = 4;
  localparam int unsigned OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_NIBBLE_MODE  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_LEN  = 3'd0,
    PH_CODE = 3'd1,
    PH_DX   = 3'd2,
    PH_DY   = 3'd3,
    PH_ABS  = 3'd4,
    PH_PAD  = 3'd5,
    PH_DONE = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SPAN  = 2'd0,
    KIND_END   = 2'd1,
    KIND_TRUNC = 2'd2,
    KIND_BAD   = 2'd3
  } kind_e;

  // escape codes following a zero length byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOI   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_e                 kind;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] column;
    logic [7:0]            count;
    logic [7:0]            color_a;
    logic [7:0]            color_b;
    logic                  final_result;
  } out_item_t;

endpackage

// File: hw/rtl/bmp_rle_decoder.sv
// bmp_rle_decoder: decodes a bitmap RLE8 / RLE4 byte stream, one byte per input
// transaction, into pixel span descriptors (row from the top, first column,
// count clipped to the image width, even and odd pixel colors) plus end of
// image, truncated and malformed markers. A byte is taken into an input
// register and, once the queue has room for two, decoded against the cursor
// state; its one or two results are written into a four-entry result queue.
// The output side reads that queue one result per transaction. Throughput is
// one byte per cycle while the queue has room; input stall rises when more
// than two results are waiting in the queue, so the output drain rate (one
// result per cycle) sets the pace when the downstream stalls or a byte yields
// two results. The first result of a byte passes the input register and the
// result queue before it is offered. Configuration writes (width, height,
// nibble mode) land at once and are meant for idle periods.
module bmp_rle_decoder
  import bmprle_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input byte channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [COORD_BITS-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] width_q, height_q;
  logic                  nibble_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= COORD_BITS'(1);
      height_q <= COORD_BITS'(1);
      nibble_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        CFG_NIBBLE_MODE:  nibble_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // zero size behaves as one
  logic [COORD_BITS-1:0] eff_w, eff_h;
  assign eff_w = (width_q  == '0) ? COORD_BITS'(1) : width_q;
  assign eff_h = (height_q == '0) ? COORD_BITS'(1) : height_q;

  // ---------------------------------------------------------------------------
  // input register and result queue occupancy
  // ---------------------------------------------------------------------------
  logic                    stage_valid_q;
  in_item_t                stage_q;
  logic [OUT_CNT_BITS-1:0] count_q, count_d;
  logic                    process;
  logic                    stage_take;

  // a byte is decoded only when the queue has room for both of its results
  assign process    = stage_valid_q && (count_q <= OUT_CNT_BITS'(OUT_DEPTH - 2));
  assign stage_take = !stage_valid_q || process;
  assign in_stall_o = !stage_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (stage_take) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_take && in_valid_i) begin
      stage_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // decoder state
  // ---------------------------------------------------------------------------
  phase_e              phase_q, phase_d;
  logic [CUR_BITS-1:0] col_q, col_d;
  logic [CUR_BITS-1:0] row_q, row_d;
  logic [7:0]          run_q, run_d;
  logic [7:0]          abs_bytes_q, abs_bytes_d;
  logic [7:0]          abs_pix_q, abs_pix_d;
  logic                pad_q, pad_d;

  logic [7:0] b;
  assign b = stage_q.stream_byte;

  // clip unit: pixels of a run that still fit in the row
  logic [7:0]          want;
  logic [CUR_BITS-1:0] w_ext, room;
  logic [7:0]          clip_c;

  assign want   = (run_q != 8'd0) ? run_q : b;
  assign w_ext  = CUR_BITS'(eff_w);
  assign room   = (col_q < w_ext) ? (w_ext - col_q) : '0;
  assign clip_c = (room < CUR_BITS'(want)) ? room[7:0] : want;

  // pixels of one absolute data byte
  logic [1:0] abs_c;
  always_comb begin
    if (nibble_q) begin
      abs_c = (abs_pix_q >= 8'd2) ? 2'd2 : abs_pix_q[1:0];
    end else begin
      abs_c = (abs_pix_q != 8'd0) ? 2'd1 : 2'd0;
    end
  end

  // bounds check after end of line or delta move
  logic [CUR_BITS-1:0] chk_col, chk_row;
  logic                out_of_bounds;

  assign chk_col       = (phase_q == PH_CODE) ? '0 : col_q;
  assign chk_row       = row_q + ((phase_q == PH_CODE) ? CUR_BITS'(1) : CUR_BITS'(b));
  assign out_of_bounds = (chk_col >= w_ext) || (chk_row >= CUR_BITS'(eff_h));

  // absolute run byte count, rounded up to whole bytes in nibble mode
  logic [7:0] abs_len;
  logic [7:0] abs_left;
  assign abs_len  = nibble_q ? 8'((9'(b) + 9'd1) >> 1) : b;
  assign abs_left = (abs_bytes_q != 8'd0) ? (abs_bytes_q - 8'd1) : 8'd0;

  // next state
  always_comb begin
    phase_d     = phase_q;
    col_d       = col_q;
    row_d       = row_q;
    run_d       = run_q;
    abs_bytes_d = abs_bytes_q;
    abs_pix_d   = abs_pix_q;
    pad_d       = pad_q;
    case (phase_q)
      PH_LEN: begin
        run_d   = b;
        phase_d = PH_CODE;
      end
      PH_CODE: begin
        if (run_q != 8'd0) begin
          col_d   = col_q + CUR_BITS'(clip_c);
          phase_d = PH_LEN;
        end else if (b == ESC_EOL) begin
          col_d   = '0;
          row_d   = chk_row;
          phase_d = out_of_bounds ? PH_DONE : PH_LEN;
        end else if (b == ESC_EOI) begin
          phase_d = PH_DONE;
        end else if (b == ESC_DELTA) begin
          phase_d = PH_DX;
        end else begin
          abs_bytes_d = abs_len;
          pad_d       = abs_len[0];
          abs_pix_d   = clip_c;
          phase_d     = PH_ABS;
        end
      end
      PH_DX: begin
        col_d   = col_q + CUR_BITS'(b);
        phase_d = PH_DY;
      end
      PH_DY: begin
        row_d   = chk_row;
        phase_d = out_of_bounds ? PH_DONE : PH_LEN;
      end
      PH_ABS: begin
        col_d       = col_q + CUR_BITS'(abs_c);
        abs_pix_d   = abs_pix_q - 8'(abs_c);
        abs_bytes_d = abs_left;
        if (abs_left == 8'd0) begin
          phase_d = pad_q ? PH_PAD : PH_LEN;
        end
      end
      PH_PAD: begin
        pad_d   = 1'b0;
        phase_d = PH_LEN;
      end
      default: phase_d = PH_DONE;
    endcase
    // the last byte returns everything to the start of a stream
    if (stage_q.last_byte) begin
      phase_d     = PH_LEN;
      col_d       = '0;
      row_d       = '0;
      run_d       = '0;
      abs_bytes_d = '0;
      abs_pix_d   = '0;
      pad_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN;
      col_q       <= '0;
      row_q       <= '0;
      run_q       <= '0;
      abs_bytes_q <= '0;
      abs_pix_q   <= '0;
      pad_q       <= 1'b0;
    end else if (process) begin
      phase_q     <= phase_d;
      col_q       <= col_d;
      row_q       <= row_d;
      run_q       <= run_d;
      abs_bytes_q <= abs_bytes_d;
      abs_pix_q   <= abs_pix_d;
      pad_q       <= pad_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result generation: one primary result and an optional truncated marker
  // ---------------------------------------------------------------------------
  out_item_t res0, res_trunc;
  logic      has0, has_trunc;
  logic      ends_done;

  always_comb begin
    has0              = 1'b0;
    ends_done         = 1'b0;
    res0              = '0;
    res0.kind         = KIND_SPAN;
    res0.row          = eff_h - COORD_BITS'(1) - row_q[COORD_BITS-1:0];
    res0.column       = col_q[COORD_BITS-1:0];
    res0.color_a      = nibble_q ? (b >> 4) : b;
    res0.color_b      = nibble_q ? (b & NIBBLE_MASK) : b;
    case (phase_q)
      PH_CODE: begin
        if (run_q != 8'd0) begin
          has0       = (clip_c != 8'd0);
          res0.count = clip_c;
        end else if (b == ESC_EOL) begin
          has0      = out_of_bounds;
          ends_done = out_of_bounds;
          res0      = '0;
          res0.kind = KIND_BAD;
        end else if (b == ESC_EOI) begin
          has0      = 1'b1;
          ends_done = 1'b1;
          res0      = '0;
          res0.kind = KIND_END;
        end
      end
      PH_DY: begin
        has0      = out_of_bounds;
        ends_done = out_of_bounds;
        res0      = '0;
        res0.kind = KIND_BAD;
      end
      PH_ABS: begin
        has0       = (abs_c != 2'd0);
        res0.count = 8'(abs_c);
      end
      PH_DONE: ends_done = 1'b1;
      default: ;
    endcase
    // stream ended without an end marker and without an earlier error
    has_trunc              = stage_q.last_byte && !ends_done;
    res0.final_result      = !has_trunc;
    res_trunc              = '0;
    res_trunc.kind         = KIND_TRUNC;
    res_trunc.final_result = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // result queue
  // ---------------------------------------------------------------------------
  out_item_t               queue_q [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wptr_q, rptr_q;
  logic [1:0]              push_n;
  logic                    pop;

  assign push_n      = process ? (2'(has0) + 2'(has_trunc)) : 2'd0;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = queue_q[rptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign count_d     = count_q + OUT_CNT_BITS'(push_n) - OUT_CNT_BITS'(pop);

  always_ff @(posedge clk_i) begin
    if (process) begin
      if (has0) begin
        queue_q[wptr_q] <= res0;
        if (has_trunc) begin
          queue_q[wptr_q + OUT_PTR_BITS'(1)] <= res_trunc;
        end
      end else if (has_trunc) begin
        queue_q[wptr_q] <= res_trunc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + OUT_PTR_BITS'(push_n);
      rptr_q  <= rptr_q + OUT_PTR_BITS'(pop);
      count_q <= count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OUT_CNT_BITS'(OUT_DEPTH))
    else $error("result queue overfilled");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && stage_q.last_byte |=> phase_q == PH_LEN && col_q == '0 && row_q == '0)
    else $error("last byte did not restart the decoder");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && phase_q == PH_DONE |=> count_q <= $past(count_q))
    else $error("result produced after end or error");

  a_abs_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ABS |-> abs_bytes_q != 8'd0)
    else $error("absolute run with no bytes left");

endmodule
